// ----- src/tbw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_pkg
// Shared types and fixed widths for the triangle barycentric weight block.
// ----------------------------------------------------------------------------
package tbw_pkg;

	localparam int COORD_W = 16;           // input coordinate width
	localparam int DIFF_W  = COORD_W + 1;  // edge difference
	localparam int PROD_W  = 2 * DIFF_W;   // one product of differences
	localparam int CROSS_W = PROD_W + 1;   // cross term, signed
	localparam int MAG_W   = PROD_W;       // magnitude of a cross term
	localparam int WGT_W   = 32;           // output weight width

	localparam int DEF_COORD_FRAC_BITS  = 4;
	localparam int DEF_WEIGHT_FRAC_BITS = 16;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [COORD_W-1:0] c_x;
		logic signed [COORD_W-1:0] c_y;
		logic signed [COORD_W-1:0] p_x;
		logic signed [COORD_W-1:0] p_y;
	} tbw_in_t;

	typedef struct packed {
		logic signed [WGT_W-1:0] weight_a;
		logic signed [WGT_W-1:0] weight_b;
		logic signed [WGT_W-1:0] weight_c;
		logic                    degenerate;
	} tbw_out_t;

endpackage

// ----- src/tbw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_front
// Edge differences, products, cross terms, magnitudes and degenerate test.
// ----------------------------------------------------------------------------
module tbw_front #(
	parameter int COORD_FRAC_BITS  = tbw_pkg::DEF_COORD_FRAC_BITS,
	parameter int WEIGHT_FRAC_BITS = tbw_pkg::DEF_WEIGHT_FRAC_BITS,
	parameter int NUM_W            = tbw_pkg::MAG_W + WEIGHT_FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  tbw_pkg::tbw_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [NUM_W-1:0]           num_x,
	output logic [NUM_W-1:0]           num_y,
	output logic [tbw_pkg::MAG_W-1:0]  den,
	output logic                       neg_x,
	output logic                       neg_y,
	output logic                       degen
);
	import tbw_pkg::*;

	localparam logic [MAG_W-1:0] UNIT_AREA = MAG_W'(1) << (2 * COORD_FRAC_BITS);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [DIFF_W-1:0] abx_s1, aby_s1, acx_s1, acy_s1, pax_s1, pay_s1;
	logic signed [PROD_W-1:0] px1_s2, px2_s2, py1_s2, py2_s2, pz1_s2, pz2_s2;
	logic signed [CROSS_W-1:0] crx_s3, cry_s3, crz_s3;
	logic [MAG_W-1:0] magx, magy, magz;
	logic [MAG_W-1:0] magx_s4, magy_s4, magz_s4;
	logic negx_s4, negy_s4, degen_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	assign magx = crx_s3[CROSS_W-1] ? MAG_W'(-crx_s3) : MAG_W'(crx_s3);
	assign magy = cry_s3[CROSS_W-1] ? MAG_W'(-cry_s3) : MAG_W'(cry_s3);
	assign magz = crz_s3[CROSS_W-1] ? MAG_W'(-crz_s3) : MAG_W'(crz_s3);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			abx_s1 <= DIFF_W'(in_data.a_x) - DIFF_W'(in_data.b_x);
			aby_s1 <= DIFF_W'(in_data.a_y) - DIFF_W'(in_data.b_y);
			acx_s1 <= DIFF_W'(in_data.a_x) - DIFF_W'(in_data.c_x);
			acy_s1 <= DIFF_W'(in_data.a_y) - DIFF_W'(in_data.c_y);
			pax_s1 <= DIFF_W'(in_data.p_x) - DIFF_W'(in_data.a_x);
			pay_s1 <= DIFF_W'(in_data.p_y) - DIFF_W'(in_data.a_y);
		end
		if (en_s2) begin
			px1_s2 <= PROD_W'(acx_s1) * PROD_W'(pay_s1);
			px2_s2 <= PROD_W'(pax_s1) * PROD_W'(acy_s1);
			py1_s2 <= PROD_W'(pax_s1) * PROD_W'(aby_s1);
			py2_s2 <= PROD_W'(abx_s1) * PROD_W'(pay_s1);
			pz1_s2 <= PROD_W'(abx_s1) * PROD_W'(acy_s1);
			pz2_s2 <= PROD_W'(acx_s1) * PROD_W'(aby_s1);
		end
		if (en_s3) begin
			crx_s3 <= CROSS_W'(px1_s2) - CROSS_W'(px2_s2);
			cry_s3 <= CROSS_W'(py1_s2) - CROSS_W'(py2_s2);
			crz_s3 <= CROSS_W'(pz1_s2) - CROSS_W'(pz2_s2);
		end
		if (en_s4) begin
			magx_s4  <= magx;
			magy_s4  <= magy;
			magz_s4  <= magz;
			negx_s4  <= crx_s3[CROSS_W-1] ^ crz_s3[CROSS_W-1];
			negy_s4  <= cry_s3[CROSS_W-1] ^ crz_s3[CROSS_W-1];
			degen_s4 <= magz < UNIT_AREA;
		end
	end

	assign out_valid = v_s4;
	assign num_x     = {magx_s4, {WEIGHT_FRAC_BITS{1'b0}}};
	assign num_y     = {magy_s4, {WEIGHT_FRAC_BITS{1'b0}}};
	assign den       = magz_s4;
	assign neg_x     = negx_s4;
	assign neg_y     = negy_s4;
	assign degen     = degen_s4;

endmodule

// ----- src/tbw_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_div_cell
// One restoring divide step for both weights: one quotient bit per cell.
// ----------------------------------------------------------------------------
module tbw_div_cell #(
	parameter int NUM_W = tbw_pkg::MAG_W + tbw_pkg::DEF_WEIGHT_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [NUM_W-1:0]          nx_i,
	input  logic [NUM_W-1:0]          ny_i,
	input  logic [NUM_W-1:0]          qx_i,
	input  logic [NUM_W-1:0]          qy_i,
	input  logic [tbw_pkg::MAG_W-1:0] rx_i,
	input  logic [tbw_pkg::MAG_W-1:0] ry_i,
	input  logic [tbw_pkg::MAG_W-1:0] d_i,
	input  logic                      sx_i,
	input  logic                      sy_i,
	input  logic                      dg_i,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [NUM_W-1:0]          nx_o,
	output logic [NUM_W-1:0]          ny_o,
	output logic [NUM_W-1:0]          qx_o,
	output logic [NUM_W-1:0]          qy_o,
	output logic [tbw_pkg::MAG_W-1:0] rx_o,
	output logic [tbw_pkg::MAG_W-1:0] ry_o,
	output logic [tbw_pkg::MAG_W-1:0] d_o,
	output logic                      sx_o,
	output logic                      sy_o,
	output logic                      dg_o
);
	import tbw_pkg::*;

	logic            v_q, en;
	logic [MAG_W:0]  tx, ty, dd;
	logic            gex, gey;

	assign en       = !v_q || out_ready;
	assign in_ready = en;
	assign dd       = {1'b0, d_i};
	assign tx       = {rx_i, nx_i[NUM_W-1]};
	assign ty       = {ry_i, ny_i[NUM_W-1]};
	assign gex      = tx >= dd;
	assign gey      = ty >= dd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	// advance the partial remainders and shift in one quotient bit
	always_ff @(posedge clk) begin
		if (en) begin
			nx_o <= {nx_i[NUM_W-2:0], 1'b0};
			ny_o <= {ny_i[NUM_W-2:0], 1'b0};
			qx_o <= {qx_i[NUM_W-2:0], gex};
			qy_o <= {qy_i[NUM_W-2:0], gey};
			rx_o <= gex ? MAG_W'(tx - dd) : MAG_W'(tx);
			ry_o <= gey ? MAG_W'(ty - dd) : MAG_W'(ty);
			d_o  <= d_i;
			sx_o <= sx_i;
			sy_o <= sy_i;
			dg_o <= dg_i;
		end
	end

	assign out_valid = v_q;

endmodule

// ----- src/tbw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_back
// Rounding, sign, weight of the first vertex, saturation and output register.
// ----------------------------------------------------------------------------
module tbw_back #(
	parameter int WEIGHT_FRAC_BITS = tbw_pkg::DEF_WEIGHT_FRAC_BITS,
	parameter int NUM_W            = tbw_pkg::MAG_W + WEIGHT_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [NUM_W-1:0]          qx,
	input  logic [NUM_W-1:0]          qy,
	input  logic [tbw_pkg::MAG_W-1:0] rx,
	input  logic [tbw_pkg::MAG_W-1:0] ry,
	input  logic [tbw_pkg::MAG_W-1:0] den,
	input  logic                      neg_x,
	input  logic                      neg_y,
	input  logic                      degen,
	output logic                      out_valid,
	input  logic                      out_ready,
	output tbw_pkg::tbw_out_t         out_data
);
	import tbw_pkg::*;

	localparam int SW = NUM_W + 4;
	localparam logic signed [SW-1:0] ONE     = SW'(1) << WEIGHT_FRAC_BITS;
	localparam logic signed [SW-1:0] SAT_MAX = SW'(32'sh7fffffff);
	localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

	logic v_s1, v_q, en_s1, en_q;
	logic [NUM_W:0] mux, muy;
	logic signed [SW-1:0] u_s1, v_s1w, wa;
	logic dg_s1;
	tbw_out_t res;

	function automatic logic signed [WGT_W-1:0] sat(input logic signed [SW-1:0] val);
		if (val > SAT_MAX)      sat = WGT_W'(SAT_MAX);
		else if (val < SAT_MIN) sat = WGT_W'(SAT_MIN);
		else                    sat = WGT_W'(val);
	endfunction

	assign en_q     = !v_q || out_ready;
	assign en_s1    = !v_s1 || en_q;
	assign in_ready = en_s1;

	// round to nearest, ties away from zero: bump when 2r >= d
	assign mux = {1'b0, qx} + (NUM_W+1)'({rx, 1'b0} >= {1'b0, den});
	assign muy = {1'b0, qy} + (NUM_W+1)'({ry, 1'b0} >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_q)  v_q  <= v_s1;
		end
	end

	assign wa = ONE - u_s1 - v_s1w;

	always_comb begin
		if (dg_s1) begin
			res.weight_a   = -WGT_W'(ONE);
			res.weight_b   = -WGT_W'(ONE);
			res.weight_c   = WGT_W'(ONE);
			res.degenerate = 1'b1;
		end else begin
			res.weight_a   = sat(wa);
			res.weight_b   = sat(u_s1);
			res.weight_c   = sat(v_s1w);
			res.degenerate = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			u_s1  <= neg_x ? -SW'(mux) : SW'(mux);
			v_s1w <= neg_y ? -SW'(muy) : SW'(muy);
			dg_s1 <= degen;
		end
		if (en_q) begin
			out_data <= res;
		end
	end

	assign out_valid = v_q;

endmodule

// ----- src/triangle_barycentric_weights.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_barycentric_weights
// Barycentric weights of a sample point in a 2D triangle, Q12.4 in, Q16.16 out.
// ----------------------------------------------------------------------------
// Pipeline: front end, then the divide chain, then the back end's registers.
// Throughput: one item per cycle unless the output stalls; the divide chain
// is one cell per quotient bit. Every stage holds its own valid, so bubbles
// collapse and a stall at the output only stops stages that are full.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
module triangle_barycentric_weights #(
	parameter int COORD_FRAC_BITS  = tbw_pkg::DEF_COORD_FRAC_BITS,
	parameter int WEIGHT_FRAC_BITS = tbw_pkg::DEF_WEIGHT_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tbw_pkg::tbw_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tbw_pkg::tbw_out_t  out_data
);
	import tbw_pkg::*;

	// dividend is |cross| << WEIGHT_FRAC_BITS; one cell per dividend bit
	localparam int NUM_W = MAG_W + WEIGHT_FRAC_BITS;

	logic             cv [0:NUM_W];
	logic             cr [0:NUM_W];
	logic [NUM_W-1:0] nx [0:NUM_W];
	logic [NUM_W-1:0] ny [0:NUM_W];
	logic [NUM_W-1:0] qx [0:NUM_W];
	logic [NUM_W-1:0] qy [0:NUM_W];
	logic [MAG_W-1:0] rx [0:NUM_W];
	logic [MAG_W-1:0] ry [0:NUM_W];
	logic [MAG_W-1:0] dd [0:NUM_W];
	logic             sx [0:NUM_W];
	logic             sy [0:NUM_W];
	logic             dg [0:NUM_W];

	// Front end: differences, products, cross terms, magnitudes.
	tbw_front #(
		.COORD_FRAC_BITS  (COORD_FRAC_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
		.NUM_W            (NUM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (cv[0]),
		.out_ready (cr[0]),
		.num_x     (nx[0]),
		.num_y     (ny[0]),
		.den       (dd[0]),
		.neg_x     (sx[0]),
		.neg_y     (sy[0]),
		.degen     (dg[0])
	);

	// Start each quotient and remainder at zero.
	assign qx[0] = '0;
	assign qy[0] = '0;
	assign rx[0] = '0;
	assign ry[0] = '0;

	// Divide chain: each cell resolves one quotient bit for both weights
	// and hands remainder, shifted dividend and quotient to the next.
	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		tbw_div_cell #(
			.NUM_W (NUM_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_ready  (cr[i]),
			.nx_i      (nx[i]),
			.ny_i      (ny[i]),
			.qx_i      (qx[i]),
			.qy_i      (qy[i]),
			.rx_i      (rx[i]),
			.ry_i      (ry[i]),
			.d_i       (dd[i]),
			.sx_i      (sx[i]),
			.sy_i      (sy[i]),
			.dg_i      (dg[i]),
			.out_valid (cv[i+1]),
			.out_ready (cr[i+1]),
			.nx_o      (nx[i+1]),
			.ny_o      (ny[i+1]),
			.qx_o      (qx[i+1]),
			.qy_o      (qy[i+1]),
			.rx_o      (rx[i+1]),
			.ry_o      (ry[i+1]),
			.d_o       (dd[i+1]),
			.sx_o      (sx[i+1]),
			.sy_o      (sy[i+1]),
			.dg_o      (dg[i+1])
		);
	end

	// Back end: round, apply signs, form the first weight, saturate, hold.
	tbw_back #(
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
		.NUM_W            (NUM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cv[NUM_W]),
		.in_ready  (cr[NUM_W]),
		.qx        (qx[NUM_W]),
		.qy        (qy[NUM_W]),
		.rx        (rx[NUM_W]),
		.ry        (ry[NUM_W]),
		.den       (dd[NUM_W]),
		.neg_x     (sx[NUM_W]),
		.neg_y     (sy[NUM_W]),
		.degen     (dg[NUM_W]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Remaining ends of the chain arrays are unused by design.
	logic unused_tail;
	assign unused_tail = ^{nx[NUM_W], ny[NUM_W]};

endmodule
